// ===== hdl/tplod_pkg.sv =====
// shared types and constants for the terrain patch lod index generator
package tplod_pkg;

    localparam int DIFF_W = 26;
    localparam int MAG_W  = 25;
    localparam int DIST_W = 50;
    localparam int VTX_W  = 5;
    localparam int CNT_W  = 5;

    localparam logic [1:0] CFG_NEAR = 2'd0;
    localparam logic [1:0] CFG_MID  = 2'd1;
    localparam logic [1:0] CFG_FAR  = 2'd2;

    localparam logic [DIST_W-1:0] NEAR_RESET = 50'd26214400;
    localparam logic [DIST_W-1:0] MID_RESET  = 50'd655360000;
    localparam logic [DIST_W-1:0] FAR_RESET  = 50'd2621440000;

    localparam logic [1:0] LVL_FULL   = 2'd0;
    localparam logic [1:0] LVL_HALF   = 2'd1;
    localparam logic [1:0] LVL_CORNER = 2'd2;

    localparam logic [CNT_W-1:0] LAST_FULL   = 5'd31;
    localparam logic [CNT_W-1:0] LAST_HALF   = 5'd7;
    localparam logic [CNT_W-1:0] LAST_CORNER = 5'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAG,
        S_SQUARE,
        S_SUM,
        S_DECIDE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             busy;
        logic             strobe;
    } t_ctrl;

endpackage

// ===== hdl/tplod_ram.sv =====
// generic simple dual-port ram with registered read
module tplod_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/terrain_patch_lod_index_generator.sv =====
// top level: terrain patch level-of-detail selection and triangle list output
//
// usage: pulse start with a patch column/row and camera position while busy
// is low; the word is taken at that edge. the block squares the distance
// from the camera to the patch centre (magnitudes, squares, sum), picks the
// level, writes it to the per-patch level ram for a patch in the grid and
// then emits one triangle word per cycle on the o_ result ports, marked by
// o_strobe, with o_last_triangle on the final one: 32, 8 or 2 triangles for
// level 0, 1, 2. busy stays high from the accepting edge to the last
// triangle, so a new word is taken only once the last patch is done.
// busy falls in the cycle after the last triangle. the level ram (one read
// at accept, one write at decide) sets the sequencing per patch.
// reset: thresholds return to their defaults and the level ram is cleared
// to level 0 by a sweep over all GRID_SIDE*GRID_SIDE entries, busy high meanwhile.
// config: write channel i_cfg_valid/o_cfg_ready with index and data, always
// ready; index 3 is ignored. write only while busy is low.
// results cannot be held off: each word is valid for exactly one cycle.
module terrain_patch_lod_index_generator
    import tplod_pkg::*;
#(
    parameter int GRID_SIDE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          i_patch_col,
    input  logic [3:0]          i_patch_row,
    input  logic signed [23:0]  i_camera_x,
    input  logic signed [23:0]  i_camera_y,
    input  logic signed [23:0]  i_camera_z,
    output logic                o_strobe,
    output logic [1:0]          o_detail_level,
    output logic [VTX_W-1:0]    o_vertex_first,
    output logic [VTX_W-1:0]    o_vertex_second,
    output logic [VTX_W-1:0]    o_vertex_third,
    output logic                o_last_triangle,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [DIST_W-1:0]   i_cfg_data
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [DIST_W-1:0] r_near, r_mid, r_far;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_idx;
    logic              r_in_grid;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [MAG_W-1:0]  r_mx, r_my, r_mz;
    logic [DIST_W-1:0] r_sx, r_sy, r_sz;
    logic [DIST_W-1:0] r_dist;
    logic [1:0]        r_lvl;
    logic [CNT_W-1:0]  r_cnt;

    logic              accept;
    logic signed [15:0] cx, cz;
    logic [AW-1:0]     idx;
    logic              in_grid;
    logic [1:0]        stored_lvl;
    logic [1:0]        n_lvl;
    logic [AW-1:0]     wr_addr;
    logic [1:0]        wr_data;
    logic [CNT_W-1:0]  last_cnt;
    logic [VTX_W-1:0]  lb, step;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // patch centre in q.8 and table index
    assign cx      = 16'((int'(i_patch_col) * 4 - 2 * GRID_SIDE + 2) * 256);
    assign cz      = 16'((2 * GRID_SIDE - 2 - int'(i_patch_row) * 4) * 256);
    assign idx     = AW'(int'(i_patch_col) + int'(i_patch_row) * GRID_SIDE);
    assign in_grid = (int'(i_patch_col) < GRID_SIDE) && (int'(i_patch_row) < GRID_SIDE);

    tplod_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_level_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ctrl.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (ctrl.rd_en),
        .i_rd_addr (idx),
        .o_rd_data (stored_lvl)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_MAG;
            S_MAG:    n_state = S_SQUARE;
            S_SQUARE: n_state = S_SUM;
            S_SUM:    n_state = S_DECIDE;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT:   if (r_cnt == last_cnt) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl    = '0;
        wr_addr = r_idx;
        wr_data = n_lvl;
        unique case (r_state)
            S_CLEAR: begin
                ctrl.busy  = 1'b1;
                ctrl.wr_en = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = LVL_FULL;
            end
            S_IDLE: begin
                ctrl.rd_en = start;
            end
            S_DECIDE: begin
                ctrl.busy  = 1'b1;
                ctrl.wr_en = r_in_grid;
            end
            S_EMIT: begin
                ctrl.busy   = 1'b1;
                ctrl.strobe = 1'b1;
            end
            default: begin
                ctrl.busy = 1'b1;
            end
        endcase
    end

    assign busy     = ctrl.busy;
    assign o_strobe = ctrl.strobe;

    // level choice, beyond far the stored level stays (level 0 outside the grid)
    always_comb begin
        priority if (r_dist < r_near) begin
            n_lvl = LVL_FULL;
        end else if (r_dist < r_mid) begin
            n_lvl = LVL_HALF;
        end else if (r_dist < r_far) begin
            n_lvl = LVL_CORNER;
        end else begin
            n_lvl = r_in_grid ? stored_lvl : LVL_FULL;
        end
    end

    // triangle decode from level and count
    always_comb begin
        unique case (r_lvl)
            LVL_FULL: begin
                last_cnt = LAST_FULL;
                step     = 5'd1;
                lb       = 5'(r_cnt[2:1]) + 5'(5 * r_cnt[4:3]);
            end
            LVL_HALF: begin
                last_cnt = LAST_HALF;
                step     = 5'd2;
                lb       = 5'(2 * r_cnt[1]) + 5'(10 * r_cnt[2]);
            end
            default: begin
                last_cnt = LAST_CORNER;
                step     = 5'd4;
                lb       = 5'd0;
            end
        endcase
        if (r_cnt[0]) begin
            o_vertex_first  = 5'(lb + 5 * step);
            o_vertex_second = 5'(lb + step);
            o_vertex_third  = 5'(lb + 6 * step);
        end else begin
            o_vertex_first  = lb;
            o_vertex_second = 5'(lb + step);
            o_vertex_third  = 5'(lb + 5 * step);
        end
    end

    assign o_detail_level  = r_lvl;
    assign o_last_triangle = (r_cnt == last_cnt);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_near     <= NEAR_RESET;
            r_mid      <= MID_RESET;
            r_far      <= FAR_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_EMIT) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_NEAR: r_near <= i_cfg_data;
                    CFG_MID:  r_mid  <= i_cfg_data;
                    CFG_FAR:  r_far  <= i_cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    // distance datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx     <= idx;
            r_in_grid <= in_grid;
            r_dx      <= DIFF_W'(i_camera_x) - DIFF_W'(cx);
            r_dy      <= DIFF_W'(i_camera_y);
            r_dz      <= DIFF_W'(i_camera_z) - DIFF_W'(cz);
        end
        if (r_state == S_MAG) begin
            r_mx <= r_dx[DIFF_W-1] ? MAG_W'(-r_dx) : r_dx[MAG_W-1:0];
            r_my <= r_dy[DIFF_W-1] ? MAG_W'(-r_dy) : r_dy[MAG_W-1:0];
            r_mz <= r_dz[DIFF_W-1] ? MAG_W'(-r_dz) : r_dz[MAG_W-1:0];
        end
        if (r_state == S_SQUARE) begin
            r_sx <= DIST_W'(r_mx * r_mx);
            r_sy <= DIST_W'(r_my * r_my);
            r_sz <= DIST_W'(r_mz * r_mz);
        end
        if (r_state == S_SUM) begin
            r_dist <= DIST_W'(r_sx + r_sy + r_sz);
        end
        if (r_state == S_DECIDE) begin
            r_lvl <= n_lvl;
        end
    end

endmodule
